// ===== design/f8e4m3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f8e4m3_pkg
// Shared types and constants for the binary32 to FP8 E4M3 encoder.
// ----------------------------------------------------------------------------
package f8e4m3_pkg;

	localparam logic [6:0]  SAT_MAG    = 7'h7e;
	localparam logic [30:0] MAG_448    = 31'h43e00000;
	localparam logic [7:0]  EXP_MIN_N  = 8'd121;
	localparam logic [7:0]  EXP_SUB_LIM = 8'd141;

	typedef enum logic [1:0] {
		KIND_NORM = 2'd0,
		KIND_SUB  = 2'd1,
		KIND_SAT  = 2'd2,
		KIND_ZERO = 2'd3
	} kind_t;

	// classified beat leaving stage 1
	typedef struct packed {
		logic        sign;
		logic        nan;
		kind_t       kind;
		logic [4:0]  shift;  // right shift amount, 21..24 (subnormal)
		logic [23:0] mant;
		logic [3:0]  exp4;   // biased E4M3 exponent (normal)
	} cls_t;

	// rounded beat leaving stage 2
	typedef struct packed {
		logic        sign;
		logic        nan;
		kind_t       kind;
		logic [4:0]  k;      // rounded significand or subnormal count
		logic [3:0]  exp4;
	} rnd_t;

endpackage

// ===== design/f8e4m3_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f8e4m3_classify
// Stage 1: decode binary32 fields, flag NaN, sort into saturate, zero, subnormal, normal.
// ----------------------------------------------------------------------------
module f8e4m3_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  logic [31:0]          bits,
	output logic                 vout,
	output f8e4m3_pkg::cls_t     cls_s1
);

	f8e4m3_pkg::cls_t c;
	logic [7:0] ex;
	logic [22:0] fr;
	logic [7:0] e_eff;
	logic [7:0] sh;

	always_comb begin
		ex = bits[30:23];
		fr = bits[22:0];
		e_eff = (ex == 8'd0) ? 8'd1 : ex;
		sh = f8e4m3_pkg::EXP_SUB_LIM - e_eff;
		c.sign = bits[31];
		c.nan = (ex == 8'hff) && (fr != 23'd0);
		c.mant = {(ex != 8'd0), fr};
		c.shift = sh[4:0];
		c.exp4 = 4'(ex - 8'd120);
		if (bits[30:0] > f8e4m3_pkg::MAG_448)
			c.kind = f8e4m3_pkg::KIND_SAT;
		else if (ex >= f8e4m3_pkg::EXP_MIN_N)
			c.kind = f8e4m3_pkg::KIND_NORM;
		else if (sh >= 8'd25)
			c.kind = f8e4m3_pkg::KIND_ZERO;
		else
			c.kind = f8e4m3_pkg::KIND_SUB;
		if (c.kind == f8e4m3_pkg::KIND_NORM)
			c.shift = 5'd20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout <= 1'b0;
		else if (en)
			vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en)
			cls_s1 <= c;
	end

endmodule

// ===== design/f8e4m3_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f8e4m3_round
// Stage 2: variable right shift with round to nearest, ties to even.
// ----------------------------------------------------------------------------
module f8e4m3_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  f8e4m3_pkg::cls_t     cls_s1,
	output logic                 vout,
	output f8e4m3_pkg::rnd_t     rnd_s2
);

	f8e4m3_pkg::rnd_t r;
	logic [23:0] q;
	logic [23:0] rem;
	logic [23:0] half;
	logic [23:0] kq;

	always_comb begin
		q = cls_s1.mant >> cls_s1.shift;
		rem = cls_s1.mant & ((24'd1 << cls_s1.shift) - 24'd1);
		half = 24'd1 << (cls_s1.shift - 5'd1);
		kq = q + 24'((rem > half) || ((rem == half) && q[0]));
		r.sign = cls_s1.sign;
		r.nan = cls_s1.nan;
		r.kind = cls_s1.kind;
		r.exp4 = cls_s1.exp4;
		r.k = kq[4:0]; // at most 16 for in-range shifts
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout <= 1'b0;
		else if (en)
			vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en)
			rnd_s2 <= r;
	end

endmodule

// ===== design/f8e4m3_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f8e4m3_pack
// Stage 3: mantissa carry, final saturation and code assembly.
// ----------------------------------------------------------------------------
module f8e4m3_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  f8e4m3_pkg::rnd_t     rnd_s2,
	output logic                 vout,
	output logic [7:0]           code_s3
);

	logic [7:0] c;
	logic [4:0] e;
	logic [2:0] m;

	always_comb begin
		e = {1'b0, rnd_s2.exp4};
		m = rnd_s2.k[2:0];
		if (rnd_s2.k[4]) begin
			e = e + 5'd1;
			m = 3'd0;
		end
		case (rnd_s2.kind)
			f8e4m3_pkg::KIND_SAT:  c = {rnd_s2.sign, f8e4m3_pkg::SAT_MAG};
			f8e4m3_pkg::KIND_ZERO: c = {rnd_s2.sign, 7'd0};
			f8e4m3_pkg::KIND_SUB:  c = {rnd_s2.sign, 3'd0, rnd_s2.k[3:0]};
			default: begin
				if (e > 5'd15 || (e == 5'd15 && m == 3'd7))
					c = {rnd_s2.sign, f8e4m3_pkg::SAT_MAG};
				else
					c = {rnd_s2.sign, e[3:0], m};
			end
		endcase
		if (rnd_s2.nan)
			c = 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout <= 1'b0;
		else if (en)
			vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en)
			code_s3 <= c;
	end

endmodule

// ===== design/float32_to_fp8_e4m3_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_to_fp8_e4m3_encoder
// Streaming binary32 to FP8 E4M3 converter, RNE, saturating.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per cycle sustained while the output is
// not stalled. Each beat passes through the classify, round and pack register
// stages. They advance together whenever the output register is empty or
// being drained, so a stall holds every beat in place.
module float32_to_fp8_e4m3_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [7:0] fp8_code
);

	logic en;
	logic v1, v2;
	f8e4m3_pkg::cls_t cls_s1;
	f8e4m3_pkg::rnd_t rnd_s2;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	f8e4m3_classify u_cls (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(s_tvalid),
		.bits(s_tdata), .vout(v1), .cls_s1(cls_s1)
	);

	f8e4m3_round u_rnd (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v1),
		.cls_s1(cls_s1), .vout(v2), .rnd_s2(rnd_s2)
	);

	f8e4m3_pack u_pck (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v2),
		.rnd_s2(rnd_s2), .vout(m_tvalid), .code_s3(m_tdata)
	);

	// a NaN beat must come out as unsigned zero
	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v2 && rnd_s2.nan) |=> (m_tdata == 8'h00))
		else $error("NaN not encoded as zero");

	// stall freezes the output stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output changed under stall");

	// saturated beats carry the max magnitude code
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v2 && !rnd_s2.nan && rnd_s2.kind == f8e4m3_pkg::KIND_SAT)
		|=> (m_tdata[6:0] == f8e4m3_pkg::SAT_MAG))
		else $error("saturation code wrong");

endmodule
